// ===== rtl/kccu_pkg.sv =====
// ----------------------------------------------------------------------------
// kccu_pkg: shared types and constants of the k-mer count-min sketch
// Default sizes, request and character codes and controller states.
// ----------------------------------------------------------------------------
package kccu_pkg;

  localparam int unsigned NUM_WAYS_DEF    = 4;
  localparam int unsigned HASH_WIDTH_DEF  = 14;
  localparam int unsigned MAX_KMER_DEF    = 32;
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  localparam logic [1:0] REQ_CHAR   = 2'd0;
  localparam logic [1:0] REQ_SEED   = 2'd1;
  localparam logic [1:0] REQ_THRESH = 2'd2;

  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_T = 8'h54;
  localparam logic [7:0] CHAR_G = 8'h47;

  localparam logic [1:0] SYM_A = 2'd0;
  localparam logic [1:0] SYM_C = 2'd1;
  localparam logic [1:0] SYM_T = 2'd2;
  localparam logic [1:0] SYM_G = 2'd3;

  localparam logic CFG_MIN_LEN = 1'b0;
  localparam logic CFG_MAX_LEN = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_UPDATE
  } kccu_state_t;

endpackage

// ===== rtl/kccu_ram.sv =====
// ----------------------------------------------------------------------------
// kccu_ram: simple dual-port synchronous memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module kccu_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/kmer_countmin_cu_sketch.sv =====
// ----------------------------------------------------------------------------
// kmer_countmin_cu_sketch: k-mer counter on a count-min sketch
// Conservative-update sketch with per-way seed hashing and heavy-hitter flag.
// ----------------------------------------------------------------------------
// Usage.
// The input channel (in_valid / in_stall) carries one item per handshake.
// A character item feeds one symbol of the current k-mer walk; walk_start
// marks the first character of a walk. Load items write one seed word or one
// threshold word; a table entry must be loaded before any walk reads it.
// The output channel (out_valid / out_stall) carries one report for every
// symbol whose k-mer length is counted: the length index, the new estimate,
// the heavy-hitter flag, the packed k-mer and the end-of-walk mark.
// A counted character passes three steps: the seed banks are read in the
// accepting cycle, the counter banks (one per way) in the next, and the
// read-modify-write with the report follows in the update step. Load items
// are written when accepted; characters that are not counted pass the hash
// step only. The result register sits between the two sides, so a
// new item is accepted while a report still waits; only the final update
// step waits when the previous report has not been taken yet.
// After reset the counter banks are cleared one row per cycle, over all
// MAX_KMER * 2**HASH_WIDTH rows; in_stall is high meanwhile. Configuration
// writes are taken at any time and should only be made while the block idles.
// ----------------------------------------------------------------------------
module kmer_countmin_cu_sketch #(
  parameter int unsigned NUM_WAYS    = kccu_pkg::NUM_WAYS_DEF,
  parameter int unsigned HASH_WIDTH  = kccu_pkg::HASH_WIDTH_DEF,
  parameter int unsigned MAX_KMER    = kccu_pkg::MAX_KMER_DEF,
  parameter int unsigned COUNT_WIDTH = kccu_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [5:0]             cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             req_type,
  input  logic                   walk_start,
  input  logic [7:0]             char_code,
  input  logic [8:0]             table_index,
  input  logic [31:0]            table_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [4:0]             length_index,
  output logic [COUNT_WIDTH-1:0] estimate,
  output logic                   is_heavy,
  output logic [63:0]            kmer_bits,
  output logic                   walk_last
);

  import kccu_pkg::*;

  localparam int unsigned LEN_W      = (MAX_KMER > 1) ? $clog2(MAX_KMER) : 1;
  localparam int unsigned SEED_BANK  = MAX_KMER * 4;
  localparam int unsigned SADDR_W    = $clog2(SEED_BANK);
  localparam int unsigned SEED_DEPTH = MAX_KMER * 4 * NUM_WAYS;
  localparam int unsigned CNT_BANK   = MAX_KMER * (2 ** HASH_WIDTH);
  localparam int unsigned CADDR_W    = $clog2(CNT_BANK);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  // Rounded-up reciprocal of the way count in 10 fractional bits. The product
  // with any 7-bit value, shifted down by 10, is the exact quotient for up to ten ways.
  localparam int unsigned WAY_RECIP  = (1024 + NUM_WAYS - 1) / NUM_WAYS;

  // Configuration registers.
  logic [5:0] min_len_cfg;
  logic [5:0] max_len_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_len_cfg <= 6'd1;
      max_len_cfg <= 6'd32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_LEN: min_len_cfg <= cfg_data;
        CFG_MAX_LEN: max_len_cfg <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [5:0] min_len;
  logic [5:0] max_len;
  assign min_len = (min_len_cfg == 6'd0) ? 6'd1 : min_len_cfg;
  assign max_len = (max_len_cfg == 6'd0 || 32'(max_len_cfg) > MAX_KMER) ?
                   6'(MAX_KMER) : max_len_cfg;

  // Controller.
  kccu_state_t state, state_next;
  logic        accept;
  logic [CADDR_W-1:0] clear_addr;
  logic        clear_done;
  logic        advance;

  assign accept     = in_valid && !in_stall;
  assign clear_done = (32'(clear_addr) == CNT_BANK - 1);
  assign advance    = !(out_valid && out_stall);

  // Walk state.
  logic [5:0]            walk_position;
  logic                  walk_active;
  logic [HASH_WIDTH-1:0] running_hash [NUM_WAYS];
  logic [63:0]           kmer_shift;
  logic [1:0]            sym_r;
  logic                  last_r;
  logic [4:0]            len_r;

  // Decode of the incoming character.
  logic       sym_ok;
  logic [1:0] sym;
  logic [5:0] pos_eff;
  logic       walk_live;
  logic       char_go;

  always_comb begin
    sym_ok = 1'b1;
    sym    = SYM_A;
    case (char_code)
      CHAR_A: sym = SYM_A;
      CHAR_C: sym = SYM_C;
      CHAR_T: sym = SYM_T;
      CHAR_G: sym = SYM_G;
      default: sym_ok = 1'b0;
    endcase
  end

  assign pos_eff   = walk_start ? 6'd0 : walk_position;
  assign walk_live = walk_start || walk_active;
  assign char_go   = accept && (req_type == REQ_CHAR) && walk_live && sym_ok &&
                     (32'(pos_eff) < MAX_KMER);

  // Hash and length arithmetic of the hash step.
  logic [HASH_WIDTH-1:0] seed_rd  [NUM_WAYS];
  logic [HASH_WIDTH-1:0] hash_new [NUM_WAYS];
  logic [5:0]            pos1;
  logic                  counted;
  logic                  last_now;
  logic [5:0]            len_full;

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      hash_new[w] = running_hash[w] ^ seed_rd[w];
    end
  end

  assign pos1     = walk_position + 6'd1;
  assign counted  = (pos1 >= min_len);
  assign last_now = (pos1 >= max_len);
  assign len_full = pos1 - min_len;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clear_done) state_next = ST_IDLE;
      ST_IDLE:   if (char_go) state_next = ST_HASH;
      ST_HASH:   state_next = counted ? ST_UPDATE : ST_IDLE;
      ST_UPDATE: if (advance) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs of the controller.
  logic seed_re;
  logic cnt_re;
  logic upd_en;
  logic clearing;

  always_comb begin
    in_stall = 1'b1;
    seed_re  = 1'b0;
    cnt_re   = 1'b0;
    upd_en   = 1'b0;
    clearing = 1'b0;
    unique case (state)
      ST_CLEAR: clearing = 1'b1;
      ST_IDLE: begin
        in_stall = 1'b0;
        seed_re  = char_go;
      end
      ST_HASH:   cnt_re = counted;
      ST_UPDATE: upd_en = advance;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clear_addr <= clear_addr + CADDR_W'(1);
      end
    end
  end

  // Walk bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_position <= '0;
      walk_active   <= 1'b0;
      kmer_shift    <= '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
        running_hash[w] <= '0;
      end
    end else if (state == ST_IDLE) begin
      if (accept && req_type == REQ_CHAR) begin
        if (walk_start) begin
          walk_active   <= 1'b1;
          walk_position <= '0;
          kmer_shift    <= '0;
          for (int w = 0; w < NUM_WAYS; w++) begin
            running_hash[w] <= '0;
          end
        end
        if (walk_live && !char_go) begin
          walk_active <= 1'b0;
        end
      end
    end else if (state == ST_HASH) begin
      walk_position <= pos1;
      kmer_shift    <= kmer_shift | (64'(sym_r) << {walk_position[4:0], 1'b0});
      for (int w = 0; w < NUM_WAYS; w++) begin
        running_hash[w] <= hash_new[w];
      end
      if (last_now) begin
        walk_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (char_go) begin
      sym_r <= sym;
    end
    if (state == ST_HASH) begin
      last_r <= last_now;
      len_r  <= len_full[4:0];
    end
  end

  // Seed banks, one per way, addressed by position and symbol.
  logic [6:0]  load_q;
  logic [17:0] load_prod;
  logic [6:0]  load_pos;
  logic [6:0]  load_way;
  logic        seed_load;

  assign load_q    = table_index[8:2];
  assign load_prod = 18'(load_q) * 18'(WAY_RECIP);
  assign load_pos  = load_prod[16:10];
  assign load_way  = load_q - 7'(32'(load_pos) * NUM_WAYS);
  assign seed_load = accept && (req_type == REQ_SEED) && (32'(table_index) < SEED_DEPTH);

  logic [SADDR_W-1:0] seed_waddr;
  logic [SADDR_W-1:0] seed_raddr;
  assign seed_waddr = SADDR_W'({load_pos[LEN_W-1:0], table_index[1:0]});
  assign seed_raddr = SADDR_W'({pos_eff[LEN_W-1:0], sym});

  // Threshold table.
  logic [LEN_W-1:0] thr_waddr;
  logic [31:0]      thr_rd;
  logic             thr_load;
  assign thr_waddr = table_index[LEN_W-1:0];
  assign thr_load  = accept && (req_type == REQ_THRESH) && (32'(table_index) < MAX_KMER);

  kccu_ram #(.DEPTH(MAX_KMER), .WIDTH(32), .ADDR_W(LEN_W)) u_thresh (
    .clk   (clk),
    .we    (thr_load),
    .waddr (thr_waddr),
    .wdata (table_value),
    .re    (cnt_re),
    .raddr (len_full[LEN_W-1:0]),
    .rdata (thr_rd)
  );

  // Counter banks and the conservative update.
  logic [COUNT_WIDTH-1:0] cnt_rd [NUM_WAYS];
  logic [COUNT_WIDTH-1:0] min_val;
  logic                   sat;
  logic [COUNT_WIDTH-1:0] est;
  logic [CADDR_W-1:0]     cnt_raddr [NUM_WAYS];
  logic [CADDR_W-1:0]     cnt_addr_r [NUM_WAYS];

  always_comb begin
    min_val = COUNT_MAX;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (cnt_rd[w] < min_val) begin
        min_val = cnt_rd[w];
      end
    end
  end

  assign sat = (min_val == COUNT_MAX);
  assign est = sat ? COUNT_MAX : min_val + COUNT_WIDTH'(1);

  generate
    for (genvar w = 0; w < NUM_WAYS; w++) begin : g_way
      logic                   bank_we;
      logic [CADDR_W-1:0]     bank_waddr;
      logic [COUNT_WIDTH-1:0] bank_wdata;

      assign cnt_raddr[w] = CADDR_W'({len_full[LEN_W-1:0], hash_new[w]});
      assign bank_we    = clearing || (upd_en && !sat && cnt_rd[w] == min_val);
      assign bank_waddr = clearing ? clear_addr : cnt_addr_r[w];
      assign bank_wdata = clearing ? '0 : est;

      always_ff @(posedge clk) begin
        if (cnt_re) begin
          cnt_addr_r[w] <= cnt_raddr[w];
        end
      end

      kccu_ram #(.DEPTH(SEED_BANK), .WIDTH(HASH_WIDTH), .ADDR_W(SADDR_W)) u_seed (
        .clk   (clk),
        .we    (seed_load && (32'(load_way) == w)),
        .waddr (seed_waddr),
        .wdata (table_value[HASH_WIDTH-1:0]),
        .re    (seed_re),
        .raddr (seed_raddr),
        .rdata (seed_rd[w])
      );

      kccu_ram #(.DEPTH(CNT_BANK), .WIDTH(COUNT_WIDTH), .ADDR_W(CADDR_W)) u_count (
        .clk   (clk),
        .we    (bank_we),
        .waddr (bank_waddr),
        .wdata (bank_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr[w]),
        .rdata (cnt_rd[w])
      );
    end
  endgenerate

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      length_index <= len_r;
      estimate     <= est;
      is_heavy     <= (32'(est) >= thr_rd);
      kmer_bits    <= kmer_shift;
      walk_last    <= last_r;
    end
  end

endmodule

// ===== rtl/kccu_checker.sv =====
// ----------------------------------------------------------------------------
// kccu_checker: port-level checks of the k-mer count-min sketch
// Watches reset, the result register and the output handshake.
// ----------------------------------------------------------------------------
module kccu_checker #(
  parameter int unsigned COUNT_WIDTH = kccu_pkg::COUNT_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [COUNT_WIDTH-1:0] estimate,
  input logic [63:0]            kmer_bits
);

  // The clearing pass holds the input side off right after reset.
  a_stall_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input accepted during counter clearing");

  // A report only appears at the end of an item's work, when input is held.
  a_report_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("report appeared without an item in flight");

  // No report is shown while reset is applied.
  a_no_report_in_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("report valid after reset");

  // A stalled report holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(estimate) && $stable(kmer_bits))
    else $error("stalled report changed");

endmodule

bind kmer_countmin_cu_sketch kccu_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_kccu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .estimate  (estimate),
  .kmer_bits (kmer_bits)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the k-mer count-min sketch
// Loads the seed and threshold tables, then drives directed and random k-mer
// walks under several length settings and checks every report in order
// against a cycle-free model of the sketch kept inside the bench.
// ----------------------------------------------------------------------------
module tb;
  import kccu_pkg::*;

  localparam int unsigned HW        = 14;
  localparam int unsigned WAYS      = 4;
  localparam int unsigned KMAX      = 32;
  localparam int unsigned SEED_N    = KMAX * 4 * WAYS;
  localparam int unsigned COUNT_TOP = 32'hFFFF_FFFF;
  localparam logic [1:0]  REQ_RESERVED = 2'd3;

  typedef struct packed {
    logic [1:0]  req;
    logic        start;
    logic [7:0]  ch;
    logic [8:0]  idx;
    logic [31:0] val;
  } sketch_item_t;

  typedef struct packed {
    logic [4:0]  len_idx;
    logic [31:0] est;
    logic        heavy;
    logic [63:0] kmer;
    logic        last;
  } sketch_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [5:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = REQ_CHAR;
  logic        walk_start = 1'b0;
  logic [7:0]  char_code = '0;
  logic [8:0]  table_index = '0;
  logic [31:0] table_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  length_index;
  logic [31:0] estimate;
  logic        is_heavy;
  logic [63:0] kmer_bits;
  logic        walk_last;

  kmer_countmin_cu_sketch u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .walk_start(walk_start), .char_code(char_code),
    .table_index(table_index), .table_value(table_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .length_index(length_index), .estimate(estimate), .is_heavy(is_heavy),
    .kmer_bits(kmer_bits), .walk_last(walk_last)
  );

  always #6 clk = ~clk;

  // Items waiting to be driven, and reports the sketch model says are due.
  sketch_item_t   pending_items[$];
  sketch_report_t due_reports[$];
  int unsigned    mismatches = 0;

  task automatic add_item(input sketch_item_t it);
    pending_items = {pending_items, it};
  endtask

  // Model state of the sketch.
  logic [5:0]  m_min_len = 6'd1;
  logic [5:0]  m_max_len = 6'd32;
  logic [5:0]  m_pos = '0;
  logic        m_active = 1'b0;
  logic [13:0] m_hash [WAYS];
  logic [63:0] m_kmer = '0;
  logic [13:0] m_seed [SEED_N];
  logic [31:0] m_thresh [KMAX];
  // Counters that were never raised read as zero, so only touched slots live here.
  int unsigned m_counts [int unsigned];

  // Six base sequences; walks reuse their prefixes so counters grow.
  logic [1:0] base_seq [6][KMAX];

  function automatic logic [7:0] char_of(input logic [1:0] s);
    case (s)
      SYM_A: return CHAR_A;
      SYM_C: return CHAR_C;
      SYM_T: return CHAR_T;
      default: return CHAR_G;
    endcase
  endfunction

  function automatic int symbol_of(input logic [7:0] c);
    case (c)
      CHAR_A: return SYM_A;
      CHAR_C: return SYM_C;
      CHAR_T: return SYM_T;
      CHAR_G: return SYM_G;
      default: return -1;
    endcase
  endfunction

  function automatic int unsigned slot_of(input int unsigned li, input int unsigned w,
                                          input logic [13:0] h);
    return (li * WAYS + w) * (1 << HW) + 32'(h);
  endfunction

  // Applies one accepted item to the sketch model and queues its report, if any.
  task automatic sketch_apply(input sketch_item_t it);
    int          sym;
    int unsigned minlen, maxlen, pos, li, minv, v, s;
    logic        last;
    sketch_report_t r;
    if (it.req == REQ_SEED) begin
      if (it.idx < SEED_N) m_seed[it.idx] = it.val[13:0];
      return;
    end
    if (it.req == REQ_THRESH) begin
      if (it.idx < KMAX) m_thresh[it.idx] = it.val;
      return;
    end
    if (it.req != REQ_CHAR) return;
    if (it.start) begin
      m_active = 1'b1;
      m_pos = '0;
      for (int w = 0; w < WAYS; w++) m_hash[w] = '0;
      m_kmer = '0;
    end
    if (!m_active) return;
    sym = symbol_of(it.ch);
    if (sym < 0) begin
      m_active = 1'b0;
      return;
    end
    minlen = (m_min_len == 0) ? 1 : 32'(m_min_len);
    maxlen = (m_max_len == 0 || m_max_len > KMAX) ? KMAX : 32'(m_max_len);
    pos = 32'(m_pos);
    if (pos >= KMAX) begin
      m_active = 1'b0;
      return;
    end
    m_kmer = m_kmer | (64'(sym) << (2 * pos));
    for (int w = 0; w < WAYS; w++)
      m_hash[w] = m_hash[w] ^ m_seed[pos * 4 * WAYS + w * 4 + sym];
    m_pos = 6'(pos + 1);
    last = (pos + 1) >= maxlen;
    if (last) m_active = 1'b0;
    if (pos + 1 < minlen) return;
    li = pos + 1 - minlen;
    minv = COUNT_TOP;
    for (int w = 0; w < WAYS; w++) begin
      s = slot_of(li, w, m_hash[w]);
      v = m_counts.exists(s) ? m_counts[s] : 0;
      if (v < minv) minv = v;
    end
    // Conservative update: only the counters sitting at the minimum move.
    if (minv < COUNT_TOP) begin
      for (int w = 0; w < WAYS; w++) begin
        s = slot_of(li, w, m_hash[w]);
        v = m_counts.exists(s) ? m_counts[s] : 0;
        if (v == minv) m_counts[s] = minv + 1;
      end
      minv = minv + 1;
    end
    r.len_idx = li[4:0];
    r.est     = minv;
    r.heavy   = minv >= m_thresh[li];
    r.kmer    = m_kmer;
    r.last    = last;
    due_reports = {due_reports, r};
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Driver: bursts of items with random gaps; the model sees each item as it is taken.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  sketch_item_t cur_item = '0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) sketch_apply(cur_item);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          req_type    <= cur_item.req;
          walk_start  <= cur_item.start;
          char_code   <= cur_item.ch;
          table_index <= cur_item.idx;
          table_value <= cur_item.val;
          in_valid    <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: each taken report is compared with the oldest due report.
  // The receiver switches between free running, random stalls and long stalls.
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  sketch_report_t want;

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (due_reports.size() == 0) begin
          report_mismatch("unexpected report", kmer_bits, 64'd0);
        end else begin
          want = due_reports.pop_front();
          if (length_index !== want.len_idx)
            report_mismatch("length_index", 64'(length_index), 64'(want.len_idx));
          if (estimate !== want.est)
            report_mismatch("estimate", 64'(estimate), 64'(want.est));
          if (is_heavy !== want.heavy)
            report_mismatch("is_heavy", 64'(is_heavy), 64'(want.heavy));
          if (kmer_bits !== want.kmer) report_mismatch("kmer_bits", kmer_bits, want.kmer);
          if (walk_last !== want.last)
            report_mismatch("walk_last", 64'(walk_last), 64'(want.last));
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 1);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  function automatic sketch_item_t char_item(input logic st, input logic [7:0] c);
    sketch_item_t it;
    it.req = REQ_CHAR;
    it.start = st;
    it.ch = c;
    it.idx = 9'($urandom);
    it.val = $urandom;
    return it;
  endfunction

  function automatic sketch_item_t load_item(input logic [1:0] rq, input logic [8:0] ix,
                                             input logic [31:0] vl);
    sketch_item_t it;
    it.req = rq;
    it.start = 1'($urandom);
    it.ch = 8'($urandom);
    it.idx = ix;
    it.val = vl;
    return it;
  endfunction

  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    do c = 8'($urandom); while (symbol_of(c) >= 0);
    return c;
  endfunction

  // One walk over a base sequence, optionally broken by a bad character.
  task automatic push_walk(input int seq, input int len, input int bad_at);
    for (int p = 0; p < len; p++) begin
      if (p == bad_at) begin
        add_item(char_item(p == 0, bad_char()));
        return;
      end
      add_item(char_item(p == 0, char_of(base_seq[seq][p % KMAX])));
    end
  endtask

  task automatic push_random(input int n);
    int pick, len;
    while (n > 0) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 34) : $urandom_range(1, 12);
        push_walk($urandom_range(0, 5), len,
                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, len) : -1);
        n -= len;
      end else if (pick < 16) begin
        // A character without the start mark; it is ignored unless a walk is still under way.
        add_item(char_item(1'b0, 8'($urandom)));
      end else if (pick < 17) begin
        add_item(load_item(REQ_RESERVED, 9'($urandom), $urandom));
      end else if (pick < 18) begin
        add_item(load_item(REQ_THRESH, 9'($urandom_range(0, 511)),
                           $urandom_range(0, 8)));
        n--;
      end else begin
        add_item(load_item(REQ_SEED, 9'($urandom), $urandom));
        n--;
      end
    end
  endtask

  // Waits until every item is taken and every report has come, then lets the
  // pipeline drain, since the last item may have caused no report.
  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || due_reports.size() > 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic ix, input logic [5:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= ix;
    cfg_data <= d;
    if (ix == CFG_MIN_LEN) m_min_len = d;
    else m_max_len = d;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  int unsigned set_min [8] = '{1, 0, 3, 32, 40, 5, 2, 1};
  int unsigned set_max [8] = '{32, 5, 8, 32, 10, 3, 0, 63};

  initial begin
    for (int s = 0; s < 6; s++)
      for (int p = 0; p < KMAX; p++) base_seq[s][p] = 2'($urandom);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Every seed and threshold entry is loaded before any walk reads them.
    for (int i = 0; i < SEED_N; i++)
      add_item(load_item(REQ_SEED, 9'(i), $urandom));
    for (int i = 0; i < KMAX; i++)
      add_item(load_item(REQ_THRESH, 9'(i),
                         (i == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 4)));
    wait_idle();
    write_reg(CFG_MIN_LEN, 6'd1);
    write_reg(CFG_MAX_LEN, 6'd32);

    // Directed: an all-G walk to full length, a short all-A walk, a restart
    // in mid walk, a walk that opens on a bad character, several ignored items.
    for (int p = 0; p < KMAX; p++) add_item(char_item(p == 0, CHAR_G));
    for (int p = 0; p < 6; p++) add_item(char_item(p == 0, CHAR_A));
    add_item(char_item(1'b1, CHAR_C));
    add_item(char_item(1'b0, CHAR_T));
    add_item(char_item(1'b1, 8'hFF));
    add_item(char_item(1'b0, CHAR_A));
    add_item(load_item(REQ_RESERVED, 9'h1FF, 32'hFFFF_FFFF));
    add_item(load_item(REQ_THRESH, 9'h1FF, 32'h0));
    add_item(load_item(REQ_THRESH, 9'd32, 32'h0));
    add_item(char_item(1'b1, CHAR_G));
    add_item(char_item(1'b0, 8'h00));
    wait_idle();

    // Random walks under each length setting, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_MIN_LEN, 6'(set_min[ph]));
      write_reg(CFG_MAX_LEN, 6'(set_max[ph]));
      push_random(100);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // The watchdog leaves room for the long counter clear after reset.
  initial begin
    #24000000;
    $display("timeout with %0d reports still due", due_reports.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
